// ===== hw/rtl/cfb_pkg.sv =====
`default_nettype none
package cfb_pkg;

  localparam int MAX_PAYLOAD = 4096;
  localparam int QUEUE_DEPTH = 4;

  localparam int LEN_W = 13;

  localparam logic REQ_START   = 1'b0;
  localparam logic REQ_PAYLOAD = 1'b1;

  localparam logic [7:0] SYNC0    = 8'h55;
  localparam logic [7:0] SYNC1    = 8'hAA;
  localparam logic [7:0] TRAILER0 = 8'hFB;
  localparam logic [7:0] TRAILER1 = 8'hF2;
  localparam logic [7:0] LOW_MASK = 8'hFF;

  typedef struct packed {
    logic       is_hdr;
    logic [7:0] cmd;
    logic [7:0] len_hi;
    logic [7:0] len_lo;
    logic [7:0] body;
    logic [7:0] sum;
    logic       trailer;
  } job_t;

endpackage
`default_nettype wire

// ===== hw/rtl/cfb_front.sv =====
`default_nettype none
module cfb_front (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     push,
  input  wire logic                     q_full,
  input  wire logic                     req_type,
  input  wire logic [7:0]               command_code,
  input  wire logic [cfb_pkg::LEN_W-1:0] payload_length,
  input  wire logic [7:0]               channel_id,
  input  wire logic [7:0]               payload_byte,
  output logic                          enq,
  output cfb_pkg::job_t                 job
);
  import cfb_pkg::*;

  localparam logic [15:0] MAX_LEN16 = 16'(MAX_PAYLOAD);

  logic             frame_open;
  logic [LEN_W-1:0] bytes_remaining;
  logic [7:0]       running_sum;

  logic             accept;
  logic             is_start;
  logic             pay_ok;
  logic [15:0]      len16;
  logic [15:0]      sat16;
  logic [15:0]      total;
  logic [LEN_W-1:0] len_sat;
  logic [LEN_W-1:0] remain_dec;
  logic [7:0]       seed;
  logic [7:0]       pay_sum;

  always_comb begin
    accept     = push && !q_full;
    is_start   = (req_type == REQ_START);
    pay_ok     = frame_open && (bytes_remaining != '0);
    len16      = 16'(payload_length);
    sat16      = (len16 > MAX_LEN16) ? MAX_LEN16 : len16;
    len_sat    = sat16[LEN_W-1:0];
    total      = sat16 + 16'd1;
    seed       = command_code + total[15:8] + (total[7:0] & LOW_MASK) + channel_id;
    pay_sum    = running_sum + payload_byte;
    remain_dec = bytes_remaining - LEN_W'(1);

    enq         = accept && (is_start || pay_ok);
    job.is_hdr  = is_start;
    job.cmd     = command_code;
    job.len_hi  = total[15:8];
    job.len_lo  = total[7:0] & LOW_MASK;
    job.body    = is_start ? channel_id : payload_byte;
    job.sum     = is_start ? seed : pay_sum;
    job.trailer = is_start ? (len_sat == '0) : (remain_dec == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open      <= 1'b0;
      bytes_remaining <= '0;
      running_sum     <= '0;
    end else if (accept) begin
      if (is_start) begin
        running_sum     <= seed;
        bytes_remaining <= len_sat;
        frame_open      <= (len_sat != '0);
      end else if (pay_ok) begin
        running_sum     <= pay_sum;
        bytes_remaining <= remain_dec;
        if (remain_dec == '0) begin
          frame_open <= 1'b0;
        end
      end
    end
  end

  a_open_matches_count: assert property (@(posedge clk) disable iff (rst)
    frame_open == (bytes_remaining != '0))
    else $error("frame_open out of step with bytes_remaining");

endmodule
`default_nettype wire

// ===== hw/rtl/cfb_queue.sv =====
`default_nettype none
module cfb_queue #(
  parameter int DEPTH = cfb_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  wire cfb_pkg::job_t wr_job,
  output logic               full,
  input  wire logic          rd_en,
  output cfb_pkg::job_t      rd_job,
  output logic               nonempty
);
  import cfb_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  job_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  always_comb begin
    full     = (count == FULL_COUNT);
    nonempty = (count != '0);
    rd_job   = mem[rd_ptr];
    do_wr    = wr_en && !full;
    do_rd    = rd_en && nonempty;
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("queue count above depth");

endmodule
`default_nettype wire

// ===== hw/rtl/cfb_back.sv =====
`default_nettype none
module cfb_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire cfb_pkg::job_t q_job,
  output logic               deq,
  input  wire logic          pop,
  output logic               empty,
  output logic [7:0]         frame_byte,
  output logic               frame_end
);
  import cfb_pkg::*;

  localparam logic [3:0] POS_SYNC0 = 4'd0;
  localparam logic [3:0] POS_SYNC1 = 4'd1;
  localparam logic [3:0] POS_CMD   = 4'd2;
  localparam logic [3:0] POS_HI    = 4'd3;
  localparam logic [3:0] POS_LO    = 4'd4;
  localparam logic [3:0] POS_BODY  = 4'd5;
  localparam logic [3:0] POS_SUM   = 4'd6;
  localparam logic [3:0] POS_TR0   = 4'd7;
  localparam logic [3:0] POS_END   = 4'd8;

  logic       out_valid;
  logic       busy;
  logic [3:0] step;

  logic       load;
  logic [3:0] cur_step;
  logic [3:0] last_step;
  logic [7:0] byte_sel;

  always_comb begin
    empty     = !out_valid;
    load      = q_valid && (!out_valid || pop);
    cur_step  = busy ? step : (q_job.is_hdr ? POS_SYNC0 : POS_BODY);
    last_step = q_job.trailer ? POS_END : POS_BODY;
    deq       = load && (cur_step == last_step);
    case (cur_step)
      POS_SYNC0: byte_sel = SYNC0;
      POS_SYNC1: byte_sel = SYNC1;
      POS_CMD:   byte_sel = q_job.cmd;
      POS_HI:    byte_sel = q_job.len_hi;
      POS_LO:    byte_sel = q_job.len_lo;
      POS_BODY:  byte_sel = q_job.body;
      POS_SUM:   byte_sel = q_job.sum;
      POS_TR0:   byte_sel = TRAILER0;
      POS_END:   byte_sel = TRAILER1;
      default:   byte_sel = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      busy      <= 1'b0;
      step      <= '0;
    end else begin
      if (load) begin
        out_valid  <= 1'b1;
        frame_byte <= byte_sel;
        frame_end  <= (cur_step == POS_END);
        if (cur_step == last_step) begin
          busy <= 1'b0;
        end else begin
          busy <= 1'b1;
          step <= cur_step + 4'd1;
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_end_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> frame_byte == TRAILER1)
    else $error("frame end on a byte other than the last trailer byte");

  a_head_held: assert property (@(posedge clk) disable iff (rst)
    busy |-> q_valid)
    else $error("queue head lost in the middle of a job");

endmodule
`default_nettype wire

// ===== hw/rtl/command_frame_builder.sv =====
// channel  | handshake          | ports
// ---------+--------------------+------------------------------------------------------
// items    | push / full        | req_type command_code payload_length channel_id
//          |                    | payload_byte
// frame    | pop / empty        | frame_byte frame_end
//
// One payload word in, one frame word out per cycle while the queue has room and pop is
// taken; a start item gives six frame words, nine with an empty payload, and a closing
// payload word gives four. The back end emits one word per cycle from the job queue
// while pop is taken; the front end takes a word each cycle until the queue is full.
// Reset is synchronous and empties the queue, the output stage and the frame state.
// A stalled pop holds the output word; the front keeps accepting until the queue fills.
`default_nettype none
module command_frame_builder #(
  parameter int QUEUE_DEPTH = cfb_pkg::QUEUE_DEPTH
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      push,
  output logic                           full,
  input  wire logic                      req_type,
  input  wire logic [7:0]                command_code,
  input  wire logic [cfb_pkg::LEN_W-1:0] payload_length,
  input  wire logic [7:0]                channel_id,
  input  wire logic [7:0]                payload_byte,
  output logic                           empty,
  input  wire logic                      pop,
  output logic [7:0]                     frame_byte,
  output logic                           frame_end
);
  import cfb_pkg::*;

  logic enq;
  job_t enq_job;
  logic q_valid;
  job_t q_job;
  logic deq;

  cfb_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .q_full        (full),
    .req_type      (req_type),
    .command_code  (command_code),
    .payload_length(payload_length),
    .channel_id    (channel_id),
    .payload_byte  (payload_byte),
    .enq           (enq),
    .job           (enq_job)
  );

  cfb_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (enq),
    .wr_job  (enq_job),
    .full    (full),
    .rd_en   (deq),
    .rd_job  (q_job),
    .nonempty(q_valid)
  );

  cfb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .deq       (deq),
    .pop       (pop),
    .empty     (empty),
    .frame_byte(frame_byte),
    .frame_end (frame_end)
  );

endmodule
`default_nettype wire
